### hdl/mept_pkg.sv
// ----------------------------------------------------------------------------
// mept_pkg
// Shared types, widths and helpers of the multi envelope peak tracker.
// ----------------------------------------------------------------------------
package mept_pkg;

    localparam int MAX_ENV_DEF = 8;
    localparam int VAL_W       = 16;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int LIVE_W      = 4;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [VAL_W-1:0] amount;
        logic [VAL_W-1:0] hold_time;
        logic [VAL_W-1:0] fade_in_time;
        logic [VAL_W-1:0] fade_out_time;
        logic [VAL_W-1:0] time_step;
    } t_in_word;

    typedef struct packed {
        logic [VAL_W-1:0]  peak_size;
        logic              shaking;
        logic              dropped;
        logic [LIVE_W-1:0] entries_live;
    } t_out_word;

    typedef struct packed {
        logic [VAL_W-1:0] peak;
        logic [VAL_W-1:0] hold_left;
        logic [VAL_W-1:0] rise_left;
        logic [VAL_W-1:0] rise_full;
        logic [VAL_W-1:0] fall_left;
        logic [VAL_W-1:0] fall_full;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic load_req;
        logic clr_idx;
        logic inc_idx;
        logic ram_rd;
        logic add_write;
        logic step_calc;
        logic mul_en;
        logic div_start;
        logic take_size;
        logic set_drop;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic req_tick;
        logic slot_valid;
        logic idx_last;
        logic direct;
        logic div_done;
        logic out_free;
    } t_dp_stat;

    function automatic logic [VAL_W-1:0] sub_clamp(input logic [VAL_W-1:0] a,
                                                   input logic [VAL_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

### hdl/multi_envelope_peak_tracker.sv
// an add scans the slots for a free one; a tick visits every slot, reads each
// live one, steps it and multiplies, and a live slot whose size needs division
// also goes through the 16-step serial divider
// one word is worked on at a time; the result register lets the next word in
// reset clears the valid bits, the live count and all control, no clearing pass
// ----------------------------------------------------------------------------
// multi_envelope_peak_tracker
// Table of trapezoid envelopes; add requests store one, ticks report the peak.
// ----------------------------------------------------------------------------
module multi_envelope_peak_tracker import mept_pkg::*; #(
    parameter int MAX_ENVELOPES = MAX_ENV_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);
    t_dp_cmd  cmd;
    t_dp_stat stat;

    mept_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mept_dp #(
        .MAX_ENVELOPES (MAX_ENVELOPES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

### hdl/mept_ram.sv
// ----------------------------------------------------------------------------
// mept_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mept_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  logic [WIDTH-1:0]       i_wdata,
    input  logic                   i_re,
    input  logic [AW-1:0]          i_raddr,
    output logic [WIDTH-1:0]       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/mept_div.sv
// ----------------------------------------------------------------------------
// mept_div
// Restoring divider, one quotient bit per cycle; quotient must fit VAL_W.
// ----------------------------------------------------------------------------
module mept_div import mept_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [VAL_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [VAL_W-1:0]  o_quotient
);
    localparam int CNT_W = $clog2(VAL_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0] r_rem;
    logic [VAL_W-1:0] r_quo;
    logic [VAL_W-1:0] r_div;

    logic [VAL_W:0]   trial;
    logic             ge;
    logic [VAL_W-1:0] n_rem;
    logic [VAL_W-1:0] n_quo;

    always_comb begin
        trial = {r_rem, r_quo[VAL_W-1]};
        ge    = trial >= {1'b0, r_div};
        n_rem = ge ? VAL_W'(trial - {1'b0, r_div}) : trial[VAL_W-1:0];
        n_quo = {r_quo[VAL_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VAL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[PROD_W-1:VAL_W];
            r_quo <= i_dividend[VAL_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### hdl/mept_dp.sv
// ----------------------------------------------------------------------------
// mept_dp
// Datapath: envelope table, valid bits, step arithmetic, peak and result word.
// ----------------------------------------------------------------------------
module mept_dp import mept_pkg::*; #(
    parameter int MAX_ENVELOPES = MAX_ENV_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_word,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_word o_out_word
);
    localparam int IDX_W  = (MAX_ENVELOPES > 1) ? $clog2(MAX_ENVELOPES) : 1;
    localparam int LCNT_W = $clog2(MAX_ENVELOPES + 1);
    localparam int LX_W   = (LCNT_W > LIVE_W) ? LCNT_W : LIVE_W;

    t_in_word                 r_req;
    logic [IDX_W-1:0]         r_idx;
    logic [MAX_ENVELOPES-1:0] r_valid;
    logic [LCNT_W-1:0]        r_live;
    logic                     r_dropped;
    logic [VAL_W-1:0]         r_largest;
    logic [VAL_W-1:0]         r_num;
    logic [VAL_W-1:0]         r_peak;
    logic [VAL_W-1:0]         r_den;
    logic                     r_direct;
    logic [VAL_W-1:0]         r_dsize;
    logic [PROD_W-1:0]        r_prod;
    logic                     r_out_valid;
    t_out_word                r_out_word;

    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] ram_wdata;
    t_entry             cur;
    t_entry             new_entry;
    t_entry             step_entry;
    logic [VAL_W-1:0]   n_num;
    logic [VAL_W-1:0]   n_den;
    logic               n_direct;
    logic [VAL_W-1:0]   n_dsize;
    logic               freed;
    logic               div_done;
    logic [VAL_W-1:0]   quotient;
    logic [VAL_W-1:0]   size;
    logic [LX_W-1:0]    live_ext;

    assign cur = t_entry'(ram_rdata);

    always_comb begin
        new_entry.peak      = r_req.amount;
        new_entry.hold_left = r_req.hold_time;
        new_entry.rise_left = r_req.fade_in_time;
        new_entry.rise_full = r_req.fade_in_time;
        new_entry.fall_left = r_req.fade_out_time;
        new_entry.fall_full = r_req.fade_out_time;
    end

    always_comb begin
        step_entry = cur;
        n_num      = '0;
        n_den      = '0;
        n_direct   = 1'b1;
        n_dsize    = cur.peak;
        if (cur.rise_left != '0) begin
            step_entry.rise_left = sub_clamp(cur.rise_left, r_req.time_step);
            if (cur.rise_full != '0 && step_entry.rise_left <= cur.rise_full) begin
                n_direct = 1'b0;
                n_num    = cur.rise_full - step_entry.rise_left;
                n_den    = cur.rise_full;
            end
        end else if (cur.hold_left != '0) begin
            step_entry.hold_left = sub_clamp(cur.hold_left, r_req.time_step);
        end else begin
            step_entry.fall_left = sub_clamp(cur.fall_left, r_req.time_step);
            if (step_entry.fall_left <= cur.fall_full) begin
                if (cur.fall_full == '0) begin
                    n_dsize = '0;
                end else begin
                    n_direct = 1'b0;
                    n_num    = step_entry.fall_left;
                    n_den    = cur.fall_full;
                end
            end
        end
        freed = (step_entry.rise_left == '0) && (step_entry.hold_left == '0) &&
                (step_entry.fall_left == '0);
    end

    assign ram_wdata = i_cmd.add_write ? ENTRY_W'(new_entry) : ENTRY_W'(step_entry);

    mept_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENVELOPES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add_write | i_cmd.step_calc),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    mept_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign size     = r_direct ? r_dsize : quotient;
    assign live_ext = LX_W'(r_live);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.add_write) begin
                r_valid[r_idx] <= 1'b1;
                r_live         <= r_live + 1'b1;
            end else if (i_cmd.step_calc && freed) begin
                r_valid[r_idx] <= 1'b0;
                r_live         <= r_live - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req     <= i_in_word;
            r_dropped <= 1'b0;
            r_largest <= '0;
        end
        if (i_cmd.clr_idx) begin
            r_idx <= '0;
        end else if (i_cmd.inc_idx) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.set_drop) begin
            r_dropped <= 1'b1;
        end
        if (i_cmd.step_calc) begin
            r_num    <= n_num;
            r_peak   <= cur.peak;
            r_den    <= n_den;
            r_direct <= n_direct;
            r_dsize  <= n_dsize;
        end
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(r_num) * PROD_W'(r_peak);
        end
        if (i_cmd.take_size && size > r_largest) begin
            r_largest <= size;
        end
        if (i_cmd.out_load) begin
            r_out_word.peak_size    <= (r_live == '0 || r_req.req_type == REQ_ADD) ?
                                       '0 : r_largest;
            r_out_word.shaking      <= (r_live != '0);
            r_out_word.dropped      <= r_dropped;
            r_out_word.entries_live <= (live_ext > LX_W'(15)) ?
                                       LIVE_W'(15) : live_ext[LIVE_W-1:0];
        end
    end

    always_comb begin
        o_stat.req_tick   = (r_req.req_type == REQ_TICK);
        o_stat.slot_valid = r_valid[r_idx];
        o_stat.idx_last   = (r_idx == IDX_W'(MAX_ENVELOPES - 1));
        o_stat.direct     = r_direct;
        o_stat.div_done   = div_done;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### hdl/mept_ctrl.sv
// ----------------------------------------------------------------------------
// mept_ctrl
// Controller: walks the table slot by slot for add and tick requests.
// ----------------------------------------------------------------------------
module mept_ctrl import mept_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCAN   = 8'b0000_0010,
        S_READ   = 8'b0000_0100,
        S_MUL    = 8'b0000_1000,
        S_DSTART = 8'b0001_0000,
        S_DWAIT  = 8'b0010_0000,
        S_ACC    = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    o_cmd.clr_idx  = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_stat.req_tick) begin
                    if (!i_stat.slot_valid) begin
                        o_cmd.add_write = 1'b1;
                        n_state         = S_FIN;
                    end else if (i_stat.idx_last) begin
                        o_cmd.set_drop = 1'b1;
                        n_state        = S_FIN;
                    end else begin
                        o_cmd.inc_idx = 1'b1;
                    end
                end else if (i_stat.slot_valid) begin
                    o_cmd.ram_rd = 1'b1;
                    n_state      = S_READ;
                end else if (i_stat.idx_last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.step_calc = 1'b1;
                n_state         = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = i_stat.direct ? S_ACC : S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.take_size = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the envelope peak tracker against a cycle-free model of its table:
// a directed run over the field extremes and corner cases, then random adds
// and ticks under random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------

typedef logic [mept_pkg::VAL_W-1:0] t_env_val;

class envelope_scoreboard;
    bit                  slot_live [mept_pkg::MAX_ENV_DEF];
    mept_pkg::t_entry    slot      [mept_pkg::MAX_ENV_DEF];
    mept_pkg::t_out_word expected_q[$];
    int                  error_count;
    int                  result_count;

    function t_env_val ratio(input t_env_val num, input t_env_val peak, input t_env_val den);
        logic [mept_pkg::PROD_W-1:0] prod;
        if (den == '0) begin
            return '0;
        end
        prod = num * peak;
        return t_env_val'(prod / den);
    endfunction

    // one tick of one live envelope, returns its size
    function t_env_val advance_slot(input int idx, input t_env_val dt);
        t_env_val         size;
        mept_pkg::t_entry e;
        e = slot[idx];
        if (e.rise_left != '0) begin
            e.rise_left = (e.rise_left > dt) ? e.rise_left - dt : '0;
            if (e.rise_full == '0 || e.rise_left > e.rise_full) begin
                size = e.peak;
            end else begin
                size = ratio(e.rise_full - e.rise_left, e.peak, e.rise_full);
            end
        end else if (e.hold_left != '0) begin
            e.hold_left = (e.hold_left > dt) ? e.hold_left - dt : '0;
            size = e.peak;
        end else begin
            e.fall_left = (e.fall_left > dt) ? e.fall_left - dt : '0;
            if (e.fall_left > e.fall_full) begin
                size = e.peak;
            end else begin
                size = ratio(e.fall_left, e.peak, e.fall_full);
            end
        end
        slot[idx] = e;
        if (e.rise_left == '0 && e.hold_left == '0 && e.fall_left == '0) begin
            slot_live[idx] = 1'b0;
        end
        return size;
    endfunction

    function void note_input(input mept_pkg::t_in_word w);
        mept_pkg::t_out_word r;
        t_env_val            largest;
        t_env_val            s;
        int                  live;
        bit                  placed;
        r       = '0;
        largest = '0;
        placed  = 1'b0;
        if (w.req_type == mept_pkg::REQ_ADD) begin
            for (int i = 0; i < mept_pkg::MAX_ENV_DEF; i++) begin
                if (!placed && !slot_live[i]) begin
                    slot_live[i]      = 1'b1;
                    slot[i].peak      = w.amount;
                    slot[i].hold_left = w.hold_time;
                    slot[i].rise_left = w.fade_in_time;
                    slot[i].rise_full = w.fade_in_time;
                    slot[i].fall_left = w.fade_out_time;
                    slot[i].fall_full = w.fade_out_time;
                    placed            = 1'b1;
                end
            end
            r.dropped = !placed;
        end else begin
            for (int i = 0; i < mept_pkg::MAX_ENV_DEF; i++) begin
                if (slot_live[i]) begin
                    s = advance_slot(i, w.time_step);
                    if (s > largest) begin
                        largest = s;
                    end
                end
            end
        end
        live = 0;
        for (int i = 0; i < mept_pkg::MAX_ENV_DEF; i++) begin
            live += slot_live[i];
        end
        r.peak_size    = (live == 0) ? '0 : largest;
        r.shaking      = (live != 0);
        r.entries_live = (live > 15) ? 4'd15 : live[mept_pkg::LIVE_W-1:0];
        expected_q.insert(expected_q.size(), r);
    endfunction

    task report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task check_result(input mept_pkg::t_out_word got);
        mept_pkg::t_out_word want;
        result_count++;
        if (expected_q.size() == 0) begin
            report($sformatf("result word %0d arrived with nothing expected", result_count));
            return;
        end
        want = expected_q[0];
        expected_q.delete(0);
        if (got.peak_size !== want.peak_size) begin
            report($sformatf("word %0d peak_size got %0d want %0d",
                             result_count, got.peak_size, want.peak_size));
        end
        if (got.shaking !== want.shaking) begin
            report($sformatf("word %0d shaking got %b want %b",
                             result_count, got.shaking, want.shaking));
        end
        if (got.dropped !== want.dropped) begin
            report($sformatf("word %0d dropped got %b want %b",
                             result_count, got.dropped, want.dropped));
        end
        if (got.entries_live !== want.entries_live) begin
            report($sformatf("word %0d entries_live got %0d want %0d",
                             result_count, got.entries_live, want.entries_live));
        end
    endtask

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb;
    import mept_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_WORDS = 1130;
    localparam int HOLD_OFF     = 700;
    localparam int DRAIN_CYCLES = 250;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    envelope_scoreboard board = new;
    bit                 calm     = 1'b0;
    int                 words_in = 0;

    multi_envelope_peak_tracker uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic send_word(input t_in_word w);
        if (!calm) begin
            while ($urandom_range(99) < 38) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        board.note_input(w);
        words_in++;
    endtask

    task automatic send_add(input int amount, input int hold, input int fin, input int fout);
        t_in_word w;
        w.req_type      = REQ_ADD;
        w.amount        = amount[VAL_W-1:0];
        w.hold_time     = hold[VAL_W-1:0];
        w.fade_in_time  = fin[VAL_W-1:0];
        w.fade_out_time = fout[VAL_W-1:0];
        w.time_step     = VAL_W'($urandom_range(65535));
        send_word(w);
    endtask

    task automatic send_tick(input int dt);
        t_in_word w;
        w.req_type      = REQ_TICK;
        w.amount        = VAL_W'($urandom_range(65535));
        w.hold_time     = VAL_W'($urandom_range(65535));
        w.fade_in_time  = VAL_W'($urandom_range(65535));
        w.fade_out_time = VAL_W'($urandom_range(65535));
        w.time_step     = dt[VAL_W-1:0];
        send_word(w);
    endtask

    // mostly short envelopes so that slots cycle, some long ones
    function automatic int rand_duration();
        int pick;
        pick = $urandom_range(99);
        if (pick < 65) begin
            return $urandom_range(40);
        end else if (pick < 90) begin
            return $urandom_range(2000);
        end
        return $urandom_range(65535);
    endfunction

    function automatic int rand_step();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            return $urandom_range(12);
        end else if (pick < 85) begin
            return $urandom_range(300);
        end
        return $urandom_range(65535);
    endfunction

    initial begin : receiver
        bit held_off;
        held_off = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                board.check_result(o_out_word);
            end
            if (!held_off && words_in >= 300) begin
                held_off = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (calm) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 38);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, then an envelope with no duration at all
        send_tick(5);
        send_add(16'hFFFF, 0, 0, 0);
        send_tick(0);
        // fill every slot with corner shapes
        send_add(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_add(0, 0, 0, 3);
        send_add(1234, 5, 10, 0);
        send_add(16'h8000, 0, 4, 8);
        send_add(16'h5555, 2, 0, 1);
        send_add(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        send_add(1, 1, 1, 1);
        send_add(16'h7FFF, 0, 16'hFFFF, 0);
        // table full
        send_add(999, 9, 9, 9);
        send_tick(0);
        send_tick(1);
        send_tick(3);
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);
        send_add(4321, 0, 0, 0);
        send_tick(16'h5555);
        send_tick(16'hAAAA);
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);
        send_tick(1);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            calm = (n >= 550 && n < 700);
            if ($urandom_range(99) < 45) begin
                send_add($urandom_range(65535), rand_duration(), rand_duration(),
                         rand_duration());
            end else begin
                send_tick(rand_step());
            end
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

### sim.f
hdl/mept_pkg.sv
hdl/mept_ram.sv
hdl/mept_div.sv
hdl/mept_dp.sv
hdl/mept_ctrl.sv
hdl/multi_envelope_peak_tracker.sv
sim/tb.sv
